/* hdl/tps_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the TLV store.
package tps_pkg;

    localparam int STORE_BYTES     = 256;
    localparam int MAX_VALUE_BYTES = 8;
    localparam int HEADER_BYTES    = 2;
    localparam int ADDR_W          = $clog2(STORE_BYTES);
    localparam int LEN_W           = ADDR_W + 1;
    localparam int IDX_W           = 4;

    typedef enum logic [1:0] {
        CMD_GET   = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_NO_SPACE  = 2'd2,
        STS_CLEARED   = 2'd3
    } sts_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_KEY,
        S_HDR,
        S_VREAD,
        S_VWAIT,
        S_APPEND,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        ADDR_POS,
        ADDR_POS1,
        ADDR_VAL,
        ADDR_APPEND
    } addr_sel_t;

    typedef struct packed {
        logic      latch_in;
        logic      adv_pos;
        logic      latch_match;
        logic      latch_size;
        logic      inc_idx;
        logic      rd_byte;
        logic      cmp_wr;
        logic      app_wr;
        logic      app_done;
        logic      clr_dirty;
        logic      st_en;
        sts_t      st_code;
        addr_sel_t addr_sel;
        logic      load_out;
    } tps_ctl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       pos_lt_used;
        logic       key_match;
        logic       idx_eq_size;
        logic       fits;
        logic       app_last;
    } tps_sts_t;

endpackage

/* hdl/tlv_parameter_store.sv */
// Top level of the TLV parameter store: controller plus datapath.
//
//  channel | ports                                               | dir
//  --------+-----------------------------------------------------+-----
//  input   | s_valid s_ready s_command s_key s_length s_value_in | in
//  result  | m_valid m_ready m_status m_size m_value_out         | out
//          |   m_modified m_dirty                                |
//
// A clear or opcode 3 goes straight to the result. A get or set walks past the stored
// records in turn, then reads or updates the value bytes of a found record; else a get
// reports not found and a set appends a new record, or is refused if it does not fit.
// The single-port byte store sets the pace.
// Reset empties the store by zeroing the used length; bytes beyond it are never read.
// The next beat is taken once the previous result is loaded into the output
// register; a stalled result holds the next command only in its final state, S_DONE.
module tlv_parameter_store (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_key,
    input  logic [3:0]  s_length,
    input  logic [63:0] s_value_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_size,
    output logic [63:0] m_value_out,
    output logic        m_modified,
    output logic        m_dirty
);
    import tps_pkg::*;

    tps_ctl_t ctl;
    tps_sts_t sts;

    tps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    tps_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .sts         (sts),
        .s_command   (s_command),
        .s_key       (s_key),
        .s_length    (s_length),
        .s_value_in  (s_value_in),
        .m_status    (m_status),
        .m_size      (m_size),
        .m_value_out (m_value_out),
        .m_modified  (m_modified),
        .m_dirty     (m_dirty)
    );

endmodule

/* hdl/tps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/tps_datapath.sv */
// Datapath: byte store, record walk pointer, value assembly and result registers.
module tps_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  tps_pkg::tps_ctl_t   ctl,
    output tps_pkg::tps_sts_t   sts,
    input  logic [1:0]          s_command,
    input  logic [7:0]          s_key,
    input  logic [3:0]          s_length,
    input  logic [63:0]         s_value_in,
    output logic [1:0]          m_status,
    output logic [3:0]          m_size,
    output logic [63:0]         m_value_out,
    output logic                m_modified,
    output logic                m_dirty
);
    import tps_pkg::*;

    logic [1:0]       cmd_reg;
    logic [7:0]       key_reg;
    logic [3:0]       len_reg;
    logic [63:0]      val_reg;
    logic [LEN_W-1:0] pos_reg,  pos_next;
    logic [LEN_W-1:0] used_reg, used_next;
    logic [IDX_W-1:0] idx_reg,  idx_next;
    logic             match_reg;
    logic [3:0]       size_reg;
    sts_t             status_reg;
    logic [63:0]      vout_reg;
    logic             changed_reg;
    logic             dirty_reg;

    logic [1:0]       out_status_reg;
    logic [3:0]       out_size_reg;
    logic [63:0]      out_vout_reg;
    logic             out_changed_reg;
    logic             out_dirty_reg;

    logic [3:0]       len_sat;
    logic [LEN_W-1:0] addr_full;
    logic [ADDR_W-1:0] addr;
    logic             we;
    logic [7:0]       wdata;
    logic [7:0]       rdata;
    logic [2:0]       vsel;
    logic [7:0]       vbyte;
    logic             diff;
    logic [LEN_W:0]   need;

    assign len_sat = (s_length > 4'(MAX_VALUE_BYTES)) ? 4'(MAX_VALUE_BYTES) : s_length;

    always_comb begin
        case (ctl.addr_sel)
            ADDR_POS:    addr_full = pos_reg;
            ADDR_POS1:   addr_full = pos_reg + LEN_W'(1);
            ADDR_VAL:    addr_full = pos_reg + LEN_W'(HEADER_BYTES) + LEN_W'(idx_reg);
            ADDR_APPEND: addr_full = used_reg + LEN_W'(idx_reg);
            default:     addr_full = pos_reg;
        endcase
    end
    assign addr = addr_full[ADDR_W-1:0];

    // During append idx walks key, size, then value bytes.
    assign vsel  = ctl.app_wr ? 3'(idx_reg - IDX_W'(HEADER_BYTES)) : idx_reg[2:0];
    assign vbyte = val_reg[{vsel, 3'b000} +: 8];
    assign diff  = (rdata != vbyte);

    always_comb begin
        if (idx_reg == IDX_W'(0)) begin
            wdata = key_reg;
        end else if (idx_reg == IDX_W'(1)) begin
            wdata = {4'b0000, len_reg};
        end else begin
            wdata = vbyte;
        end
        if (ctl.cmp_wr) begin
            wdata = vbyte;
        end
    end

    assign we = ctl.app_wr | (ctl.cmp_wr & diff);

    tps_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (addr),
        .wdata (wdata),
        .raddr (addr),
        .rdata (rdata)
    );

    assign need = {1'b0, used_reg} + (LEN_W+1)'(HEADER_BYTES) + (LEN_W+1)'(len_reg);

    assign sts.cmd         = cmd_reg;
    assign sts.pos_lt_used = (pos_reg < used_reg);
    assign sts.key_match   = match_reg;
    assign sts.idx_eq_size = (idx_reg == IDX_W'(size_reg));
    assign sts.fits        = (need < (LEN_W+1)'(STORE_BYTES));
    assign sts.app_last    = (idx_reg == IDX_W'(len_reg) + IDX_W'(1));

    always_comb begin
        pos_next  = pos_reg;
        used_next = used_reg;
        idx_next  = idx_reg;
        if (ctl.latch_in) begin
            pos_next = '0;
            idx_next = '0;
        end
        if (ctl.adv_pos) begin
            pos_next = pos_reg + LEN_W'(rdata) + LEN_W'(HEADER_BYTES);
        end
        if (ctl.latch_size) begin
            idx_next = '0;
        end
        if (ctl.inc_idx || (ctl.app_wr && !ctl.app_done)) begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (ctl.app_done) begin
            used_next = need[LEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            used_reg  <= '0;
            idx_reg   <= '0;
            dirty_reg <= 1'b0;
            size_reg  <= '0;
        end else begin
            pos_reg  <= pos_next;
            used_reg <= used_next;
            idx_reg  <= idx_next;
            if (ctl.clr_dirty) begin
                dirty_reg <= 1'b0;
            end else if (ctl.app_done || (ctl.cmp_wr && diff)) begin
                dirty_reg <= 1'b1;
            end
            if (ctl.latch_in) begin
                size_reg <= '0;
            end else if (ctl.latch_size) begin
                size_reg <= rdata[3:0];
            end else if (ctl.app_done) begin
                size_reg <= len_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.latch_in) begin
            cmd_reg     <= s_command;
            key_reg     <= s_key;
            len_reg     <= len_sat;
            val_reg     <= s_value_in;
            vout_reg    <= '0;
            changed_reg <= 1'b0;
            status_reg  <= STS_OK;
        end else begin
            if (ctl.st_en) begin
                status_reg <= ctl.st_code;
            end
            if (ctl.rd_byte) begin
                vout_reg[{idx_reg[2:0], 3'b000} +: 8] <= rdata;
            end
            if (ctl.app_done || (ctl.cmp_wr && diff)) begin
                changed_reg <= 1'b1;
            end
        end
        if (ctl.latch_match) begin
            match_reg <= (rdata == key_reg);
        end
    end

    // Result beat register; holds while the consumer stalls.
    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            out_status_reg  <= status_reg;
            out_size_reg    <= size_reg;
            out_vout_reg    <= vout_reg;
            out_changed_reg <= changed_reg;
            out_dirty_reg   <= dirty_reg;
        end
    end

    assign m_status    = out_status_reg;
    assign m_size      = out_size_reg;
    assign m_value_out = out_vout_reg;
    assign m_modified  = out_changed_reg;
    assign m_dirty     = out_dirty_reg;

    // Records always tile the used region, so the walk lands exactly on its end.
    a_pos_in_used: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= used_reg)
        else $error("walk pointer ran past used length");

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg < LEN_W'(STORE_BYTES))
        else $error("used length reached store size");

    a_size_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.latch_size |=> size_reg <= 4'(MAX_VALUE_BYTES))
        else $error("stored record size exceeds value limit");

endmodule

/* hdl/tps_ctrl.sv */
// Controller: sequences record walk, value read/update, append, clear and result beat.
module tps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  tps_pkg::tps_sts_t sts,
    output tps_pkg::tps_ctl_t ctl
);
    import tps_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        ctl.st_code  = STS_OK;
        ctl.addr_sel = ADDR_POS;
        s_ready    = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.latch_in = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (sts.cmd)
                    CMD_GET, CMD_SET: state_next = S_SCAN;
                    CMD_CLEAR: begin
                        ctl.clr_dirty = 1'b1;
                        ctl.st_en     = 1'b1;
                        ctl.st_code   = STS_CLEARED;
                        state_next    = S_DONE;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_SCAN: begin
                ctl.addr_sel = ADDR_POS;
                if (sts.pos_lt_used) begin
                    state_next = S_KEY;
                end else if (sts.cmd == CMD_GET) begin
                    ctl.st_en   = 1'b1;
                    ctl.st_code = STS_NOT_FOUND;
                    state_next  = S_DONE;
                end else if (sts.fits) begin
                    state_next = S_APPEND;
                end else begin
                    ctl.st_en   = 1'b1;
                    ctl.st_code = STS_NO_SPACE;
                    state_next  = S_DONE;
                end
            end
            S_KEY: begin
                // key byte arrives; fetch size byte
                ctl.addr_sel    = ADDR_POS1;
                ctl.latch_match = 1'b1;
                state_next      = S_HDR;
            end
            S_HDR: begin
                if (sts.key_match) begin
                    ctl.latch_size = 1'b1;
                    state_next     = S_VREAD;
                end else begin
                    ctl.adv_pos = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_VREAD: begin
                ctl.addr_sel = ADDR_VAL;
                if (sts.idx_eq_size) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_VWAIT;
                end
            end
            S_VWAIT: begin
                ctl.addr_sel = ADDR_VAL;
                ctl.inc_idx  = 1'b1;
                if (sts.cmd == CMD_GET) begin
                    ctl.rd_byte = 1'b1;
                end else begin
                    ctl.cmp_wr = 1'b1;
                end
                state_next = S_VREAD;
            end
            S_APPEND: begin
                ctl.addr_sel = ADDR_APPEND;
                ctl.app_wr   = 1'b1;
                if (sts.app_last) begin
                    ctl.app_done = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (ctl.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load_out |-> (!m_valid_reg || m_ready))
        else $error("result beat overwritten while pending");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load_out |=> m_valid_reg && state_reg == S_IDLE)
        else $error("loaded result not presented");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second beat accepted while command in flight");

    a_write_scope: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.app_wr || ctl.cmp_wr) |-> sts.cmd == CMD_SET)
        else $error("store written outside a set command");

endmodule
